@@ rtl/bdte_pkg.sv @@
// Shared types, tables and constants for the broken-down time to epoch converter.
// Used by every module of the block; depends on nothing else.
package bdte_pkg;

  localparam logic [1:0] SAT_NONE = 2'd0;
  localparam logic [1:0] SAT_HIGH = 2'd1;
  localparam logic [1:0] SAT_LOW  = 2'd2;

  localparam logic [31:0] EPOCH_MAX = 32'h7fffffff;
  localparam logic [31:0] EPOCH_MIN = 32'h80000001;

  localparam int SEC_BIAS  = 69;
  localparam int MIN_BIAS  = 70;
  localparam int HOUR_BIAS = 46;
  localparam int MON_BIAS  = 11;

  // Days before each month of a year that starts on the first of March.
  localparam logic [8:0] DOY_MAR [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] sec;
  } hms_t;

  typedef struct packed {
    logic signed [12:0] minute;
    logic signed [10:0] hour;
    logic signed [10:0] mday;
    logic signed [7:0]  mon;
    logic [7:0]         year;
  } tag0_t;

  typedef struct packed {
    logic [5:0]         sec;
    logic signed [10:0] hour;
    logic signed [10:0] mday;
    logic signed [7:0]  mon;
    logic [7:0]         year;
  } tag1_t;

  typedef struct packed {
    logic [5:0]         sec;
    logic [5:0]         minute;
    logic signed [10:0] mday;
    logic signed [7:0]  mon;
    logic [7:0]         year;
  } tag2_t;

  typedef struct packed {
    hms_t               hms;
    logic signed [11:0] mday;
    logic [7:0]         year;
  } tag3_t;

  typedef struct packed {
    logic [31:0]       epoch;
    hms_t              hms;
    logic [4:0]        mday;
    logic [3:0]        mon;
    logic signed [9:0] year;
    logic [8:0]        yday;
    logic [2:0]        wday;
    logic [1:0]        sat;
  } result_t;

  // Whole centuries in a year of a 400-year era.
  function automatic logic [1:0] centuries(input logic [8:0] y);
    logic [1:0] c;
    if (y >= 9'd300) begin
      c = 2'd3;
    end else if (y >= 9'd200) begin
      c = 2'd2;
    end else if (y >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

  // Leap year test on a year counted from 1600.
  function automatic logic is_leap(input logic [9:0] y);
    logic c100;
    logic c400;
    c100 = (y == 10'd0) || (y == 10'd100) || (y == 10'd200) || (y == 10'd300) ||
           (y == 10'd400) || (y == 10'd500) || (y == 10'd600) || (y == 10'd700) ||
           (y == 10'd800) || (y == 10'd900) || (y == 10'd1000);
    c400 = (y == 10'd0) || (y == 10'd400) || (y == 10'd800);
    return (y[1:0] == 2'd0) && (!c100 || c400);
  endfunction

endpackage

@@ rtl/bdte_floor_div.sv @@
// Two-stage floor division of a signed field by a constant, with remainder.
// Uses bdte_pkg; a tag travels alongside the value.
module bdte_floor_div
  import bdte_pkg::*;
#(
  parameter int W_IN    = 13,
  parameter int DIVISOR = 60,
  parameter int BIAS    = SEC_BIAS,
  parameter int W_Q     = 8,
  parameter int W_R     = 6,
  parameter int TW      = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic                  in_valid,
  input  logic signed [W_IN-1:0] in_value,
  input  logic [TW-1:0]         in_tag,
  output logic                  out_valid,
  output logic signed [W_Q-1:0] out_q,
  output logic [W_R-1:0]        out_r,
  output logic [TW-1:0]         out_tag
);

  localparam int XMAX = 2**(W_IN-1) - 1 + BIAS * DIVISOR;
  localparam int WX   = $clog2(XMAX + 1);
  localparam int SH   = WX + 4;
  localparam int MUL  = (2**SH) / DIVISOR;
  localparam int WQ0  = $clog2(XMAX / DIVISOR + 2);
  localparam int WP   = SH + WQ0;

  logic signed [WX:0] x_s;
  logic [WP-1:0]      prod;
  logic [WX-1:0]      a_x;
  logic [WQ0-1:0]     a_q0;
  logic [TW-1:0]      a_tag;
  logic               a_valid;
  logic [WX-1:0]      qd;
  logic [WX-1:0]      r0;
  logic               fix;
  logic               b_valid;

  assign x_s  = (WX+1)'(in_value) + (WX+1)'(BIAS * DIVISOR);
  assign prod = WP'(x_s[WX-1:0]) * WP'(MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (ce) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  assign qd  = WX'(a_q0) * WX'(DIVISOR);
  assign r0  = a_x - qd;
  assign fix = r0 >= WX'(DIVISOR);

  always_ff @(posedge clk) begin
    if (ce) begin
      a_x     <= x_s[WX-1:0];
      a_q0    <= prod[SH +: WQ0];
      a_tag   <= in_tag;
      out_q   <= $signed(W_Q'(a_q0) + W_Q'(fix) - W_Q'(BIAS));
      out_r   <= fix ? W_R'(r0 - WX'(DIVISOR)) : W_R'(r0);
      out_tag <= a_tag;
    end
  end

  assign out_valid = b_valid;

endmodule

@@ rtl/bdte_date_core.sv @@
// Twelve-stage date pipeline: day number, calendar date, day of year and week, epoch.
// Uses bdte_pkg for its tables, field types and leap and century helpers.
module bdte_date_core
  import bdte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  hms_t              in_hms,
  input  logic signed [11:0] in_mday,
  input  logic [3:0]        in_mon,
  input  logic signed [9:0] in_year,
  output logic              out_valid,
  output result_t           out_res
);

  localparam int NST = 12;
  localparam logic [17:0] ERA_DAYS  = 18'd146097;
  localparam logic [17:0] EPOCH_DAY = 18'd135080;
  localparam logic [39:0] M7        = 40'd2396745;
  localparam logic [35:0] M1460     = 36'd183859;
  localparam logic [37:0] M365      = 38'd735439;

  logic [NST-1:0] vld;

  logic        lowm;
  logic [9:0]  yy;
  logic        era1;
  logic [3:0]  mp;
  logic [8:0]  c1_yoe;
  logic        c1_era;
  logic [8:0]  c1_doym;
  logic signed [11:0] c1_mday;
  hms_t        c1_hms;

  logic [17:0] c2_base;
  logic signed [12:0] c2_extra;
  logic        c2_era;
  hms_t        c2_hms;

  logic [17:0] c3_d;
  hms_t        c3_hms;

  logic        era2;
  logic [17:0] wx;
  logic [39:0] p7;
  logic [17:0] c4_doe;
  logic        c4_era;
  logic signed [17:0] c4_edays;
  logic [17:0] c4_wx;
  logic [15:0] c4_q7;
  hms_t        c4_hms;

  logic [35:0] p1460;
  logic [3:0]  r7;
  logic [17:0] c5_doe;
  logic        c5_era;
  logic [2:0]  c5_c365;
  logic [6:0]  c5_q1460;
  logic [2:0]  c5_wday;
  logic signed [34:0] c5_ep;
  logic [16:0] c5_tod;
  hms_t        c5_hms;

  logic [17:0] r1460;
  logic [17:0] q1460;
  logic [17:0] c6_t;
  logic [17:0] c6_doe;
  logic        c6_era;
  logic [2:0]  c6_wday;
  logic [31:0] c6_epoch;
  hms_t        c6_hms;

  logic [37:0] p365;
  logic [8:0]  c7_q;
  logic [17:0] c7_t;
  logic [17:0] c7_doe;
  logic        c7_era;
  logic [2:0]  c7_wday;
  logic [31:0] c7_epoch;
  hms_t        c7_hms;

  logic [17:0] r365;
  logic [8:0]  c8_yoe;
  logic [17:0] c8_doe;
  logic        c8_era;
  logic [2:0]  c8_wday;
  logic [31:0] c8_epoch;
  hms_t        c8_hms;

  logic [17:0] ystart;
  logic [8:0]  c9_doy;
  logic [9:0]  c9_yrel;
  logic [2:0]  c9_wday;
  logic [31:0] c9_epoch;
  hms_t        c9_hms;

  logic [3:0]  cnt;
  logic [3:0]  c10_mp;
  logic [8:0]  c10_doy;
  logic [9:0]  c10_yrel;
  logic [2:0]  c10_wday;
  logic [31:0] c10_epoch;
  hms_t        c10_hms;

  logic [9:0]  yr;
  logic [4:0]  c11_d;
  logic [3:0]  c11_m;
  logic [9:0]  c11_yr;
  logic signed [9:0] c11_year;
  logic [2:0]  c11_wday;
  logic [31:0] c11_epoch;
  hms_t        c11_hms;

  logic        leap;
  logic [1:0]  sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  assign out_valid = vld[NST-1];

  assign lowm = in_mon < 4'd2;
  assign yy   = 10'(11'(in_year) + 11'd300 - 11'(lowm));
  assign era1 = yy >= 10'd400;
  assign mp   = lowm ? in_mon + 4'd10 : in_mon - 4'd2;

  assign era2 = c3_d >= ERA_DAYS;
  assign wx   = c3_d + 18'd3;
  assign p7   = 40'(wx) * M7;

  assign p1460 = 36'(c4_doe) * M1460;
  assign r7    = 4'(c4_wx - 18'(c4_q7) * 18'd7);

  assign r1460 = c5_doe - 18'(c5_q1460) * 18'd1460;
  assign q1460 = 18'(c5_q1460) + 18'(r1460 >= 18'd1460);

  assign p365 = 38'(c6_t) * M365;

  assign r365 = c7_t - 18'(c7_q) * 18'd365;

  assign ystart = 18'(c8_yoe) * 18'd365 + 18'(c8_yoe[8:2]) - 18'(centuries(c8_yoe));

  always_comb begin
    cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      cnt = cnt + 4'(c9_doy >= DOY_MAR[k]);
    end
  end

  assign yr   = c10_yrel + 10'(c10_mp >= 4'd10);
  assign leap = is_leap(c11_yr);

  always_comb begin
    if (c11_year > 10'sd137) begin
      sat = SAT_HIGH;
    end else if (c11_year < 10'sd2) begin
      sat = SAT_LOW;
    end else begin
      sat = SAT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c1_yoe  <= era1 ? 9'(yy - 10'd400) : yy[8:0];
      c1_era  <= era1;
      c1_doym <= DOY_MAR[mp];
      c1_mday <= in_mday;
      c1_hms  <= in_hms;

      c2_base  <= 18'(c1_yoe) * 18'd365 + 18'(c1_yoe[8:2]) - 18'(centuries(c1_yoe));
      c2_extra <= 13'(c1_mday) + $signed({4'd0, c1_doym}) - 13'sd1;
      c2_era   <= c1_era;
      c2_hms   <= c1_hms;

      c3_d   <= c2_base + 18'(c2_extra) + (c2_era ? ERA_DAYS : 18'd0);
      c3_hms <= c2_hms;

      c4_doe   <= c3_d - (era2 ? ERA_DAYS : 18'd0);
      c4_era   <= era2;
      c4_edays <= $signed(c3_d - EPOCH_DAY);
      c4_wx    <= wx;
      c4_q7    <= p7[39:24];
      c4_hms   <= c3_hms;

      c5_doe   <= c4_doe;
      c5_era   <= c4_era;
      c5_c365  <= 3'(c4_doe >= 18'd36524) + 3'(c4_doe >= 18'd73048) +
                  3'(c4_doe >= 18'd109572) + 3'(c4_doe >= 18'd146096);
      c5_q1460 <= p1460[34:28];
      c5_wday  <= (r7 >= 4'd7) ? 3'(r7 - 4'd7) : r7[2:0];
      c5_ep    <= 35'(c4_edays) * 35'sd86400;
      c5_tod   <= 17'(c4_hms.hour) * 17'd3600 + 17'(c4_hms.minute) * 17'd60 +
                  17'(c4_hms.sec);
      c5_hms   <= c4_hms;

      c6_t     <= c5_doe - q1460 + 18'(c5_c365) - 18'(c5_doe == 18'd146096);
      c6_doe   <= c5_doe;
      c6_era   <= c5_era;
      c6_wday  <= c5_wday;
      c6_epoch <= 32'(c5_ep + $signed({18'd0, c5_tod}));
      c6_hms   <= c5_hms;

      c7_q     <= p365[36:28];
      c7_t     <= c6_t;
      c7_doe   <= c6_doe;
      c7_era   <= c6_era;
      c7_wday  <= c6_wday;
      c7_epoch <= c6_epoch;
      c7_hms   <= c6_hms;

      c8_yoe   <= c7_q + 9'(r365 >= 18'd365);
      c8_doe   <= c7_doe;
      c8_era   <= c7_era;
      c8_wday  <= c7_wday;
      c8_epoch <= c7_epoch;
      c8_hms   <= c7_hms;

      c9_doy   <= 9'(c8_doe - ystart);
      c9_yrel  <= 10'(c8_yoe) + (c8_era ? 10'd400 : 10'd0);
      c9_wday  <= c8_wday;
      c9_epoch <= c8_epoch;
      c9_hms   <= c8_hms;

      c10_mp    <= cnt;
      c10_doy   <= c9_doy;
      c10_yrel  <= c9_yrel;
      c10_wday  <= c9_wday;
      c10_epoch <= c9_epoch;
      c10_hms   <= c9_hms;

      c11_d     <= 5'(c10_doy - DOY_MAR[c10_mp] + 9'd1);
      c11_m     <= (c10_mp < 4'd10) ? c10_mp + 4'd2 : c10_mp - 4'd10;
      c11_yr    <= yr;
      c11_year  <= $signed(yr - 10'd300);
      c11_wday  <= c10_wday;
      c11_epoch <= c10_epoch;
      c11_hms   <= c10_hms;

      out_res.epoch <= (sat == SAT_HIGH) ? EPOCH_MAX :
                       (sat == SAT_LOW) ? EPOCH_MIN : c11_epoch;
      out_res.hms   <= c11_hms;
      out_res.mday  <= c11_d;
      out_res.mon   <= c11_m;
      out_res.year  <= c11_year;
      out_res.yday  <= DAYS_BEFORE[c11_m] + 9'(c11_d) - 9'd1 +
                       9'((c11_m > 4'd1) && leap);
      out_res.wday  <= (sat == SAT_NONE) ? c11_wday : 3'd0;
      out_res.sat   <= sat;
    end
  end

endmodule

@@ rtl/broken_down_time_to_epoch_unit.sv @@
// Broken-down date and time to seconds since 1970, top level.
// Uses bdte_pkg, bdte_floor_div and bdte_date_core.
//
// One transfer enters per clock while the output is not stalled; it passes the four
// carries (seconds, minutes, hours, months, two stages each) and then the date pipeline
// that builds a day number and splits it back into a calendar date. The whole pipeline
// holds when a finished result is not taken. Out-of-range fields are normalised with
// floor carries and Gregorian leap years; full years after 2037 or before 1902 give
// +/-0x7fffffff, a saturation code in tuser and weekday 0.
module broken_down_time_to_epoch_unit
  import bdte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sec[12:0], min[25:13], hour[36:26], mday[47:37], mon[55:48], year[63:56]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // epoch_seconds[31:0], sec[37:32], min[43:38], hour[48:44], mday[53:49],
  // mon[57:54], year[67:58], yday[76:68], wday[79:77]
  output logic [79:0] m_tdata,
  // saturated[1:0]
  output logic [1:0]  m_tuser
);

  logic ce;

  tag0_t tag0_in, tag0_out;
  tag1_t tag1_in, tag1_out;
  tag2_t tag2_in, tag2_out;
  tag3_t tag3_in, tag3_out;

  logic v0, v1, v2, v3;
  logic signed [7:0]  qs, qm;
  logic signed [6:0]  qh;
  logic signed [4:0]  qmo;
  logic [5:0]         rs, rm;
  logic [4:0]         rh;
  logic [3:0]         rmo;
  logic signed [13:0] min2;
  logic signed [11:0] hour2;
  logic signed [9:0]  year2;
  logic               core_valid;
  result_t            res;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  assign tag0_in.minute = $signed(s_tdata[25:13]);
  assign tag0_in.hour   = $signed(s_tdata[36:26]);
  assign tag0_in.mday   = $signed(s_tdata[47:37]);
  assign tag0_in.mon    = $signed(s_tdata[55:48]);
  assign tag0_in.year   = s_tdata[63:56];

  bdte_floor_div #(
    .W_IN(13), .DIVISOR(60), .BIAS(SEC_BIAS), .W_Q(8), .W_R(6), .TW($bits(tag0_t))
  ) u_sec_div (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(s_tvalid && s_tready), .in_value($signed(s_tdata[12:0])),
    .in_tag(tag0_in),
    .out_valid(v0), .out_q(qs), .out_r(rs), .out_tag(tag0_out)
  );

  assign min2          = 14'(tag0_out.minute) + 14'(qs);
  assign tag1_in.sec   = rs;
  assign tag1_in.hour  = tag0_out.hour;
  assign tag1_in.mday  = tag0_out.mday;
  assign tag1_in.mon   = tag0_out.mon;
  assign tag1_in.year  = tag0_out.year;

  bdte_floor_div #(
    .W_IN(14), .DIVISOR(60), .BIAS(MIN_BIAS), .W_Q(8), .W_R(6), .TW($bits(tag1_t))
  ) u_min_div (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(v0), .in_value(min2), .in_tag(tag1_in),
    .out_valid(v1), .out_q(qm), .out_r(rm), .out_tag(tag1_out)
  );

  assign hour2          = 12'(tag1_out.hour) + 12'(qm);
  assign tag2_in.sec    = tag1_out.sec;
  assign tag2_in.minute = rm;
  assign tag2_in.mday   = tag1_out.mday;
  assign tag2_in.mon    = tag1_out.mon;
  assign tag2_in.year   = tag1_out.year;

  bdte_floor_div #(
    .W_IN(12), .DIVISOR(24), .BIAS(HOUR_BIAS), .W_Q(7), .W_R(5), .TW($bits(tag2_t))
  ) u_hour_div (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(v1), .in_value(hour2), .in_tag(tag2_in),
    .out_valid(v2), .out_q(qh), .out_r(rh), .out_tag(tag2_out)
  );

  assign tag3_in.hms.hour   = rh;
  assign tag3_in.hms.minute = tag2_out.minute;
  assign tag3_in.hms.sec    = tag2_out.sec;
  assign tag3_in.mday       = 12'(tag2_out.mday) + 12'(qh);
  assign tag3_in.year       = tag2_out.year;

  bdte_floor_div #(
    .W_IN(8), .DIVISOR(12), .BIAS(MON_BIAS), .W_Q(5), .W_R(4), .TW($bits(tag3_t))
  ) u_mon_div (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(v2), .in_value(tag2_out.mon), .in_tag(tag3_in),
    .out_valid(v3), .out_q(qmo), .out_r(rmo), .out_tag(tag3_out)
  );

  assign year2 = $signed({2'b00, tag3_out.year}) + 10'(qmo);

  bdte_date_core u_core (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(v3), .in_hms(tag3_out.hms), .in_mday(tag3_out.mday),
    .in_mon(rmo), .in_year(year2),
    .out_valid(core_valid), .out_res(res)
  );

  assign m_tvalid = core_valid;
  assign m_tdata  = {res.wday, res.yday, res.year, res.mon, res.mday,
                     res.hms.hour, res.hms.minute, res.hms.sec, res.epoch};
  assign m_tuser  = res.sat;

`ifndef SYNTHESIS
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow the output stall");

  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == SAT_NONE || m_tuser == SAT_HIGH || m_tuser == SAT_LOW))
    else $error("unknown saturation code");

  a_sat_wday: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != SAT_NONE) |-> (m_tdata[79:77] == 3'd0))
    else $error("saturated result with a weekday");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[57:54] <= 4'd11 && m_tdata[53:49] != 5'd0 &&
                  m_tdata[79:77] <= 3'd6))
    else $error("normalised date out of range");
`endif

endmodule
